@@ rtl/gpb_pkg.sv @@
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared constants, codes and types of the gpio port bank.
// ----------------------------------------------------------------------------
package gpb_pkg;

	localparam int NUM_PORTS = 3;
	localparam int PINS_PER_PORT = 16;
	localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	localparam int CMD_W = 2;
	localparam int SEL_W = 8;
	localparam int PIN_W = 16;
	localparam int WORD_W = 12;

	// pins that exist in a port
	localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((17'd1 << PINS_PER_PORT) - 17'd1);

	// commands
	localparam logic [CMD_W-1:0] CMD_CONFIG = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	// pin modes
	localparam logic [1:0] MODE_INPUT  = 2'd0;
	localparam logic [1:0] MODE_OUTPUT = 2'd1;
	localparam logic [1:0] MODE_ALT    = 2'd2;
	localparam logic [1:0] MODE_ANALOG = 2'd3;

	// mode word field positions
	localparam int PULL_LSB  = 0;
	localparam int OD_BIT    = 2;
	localparam int MODE_LSB  = 3;
	localparam int SPEED_LSB = 5;
	localparam int AF_LSB    = 8;

	typedef struct packed {
		logic                  wr;
		logic [CMD_W-1:0]      cmd;
		logic [PORT_W-1:0]     port;
		logic [WORD_W-1:0]     word;
	} lane_ctl_t;

	typedef struct packed {
		logic [PIN_W-1:0] read_data;
		logic [PIN_W-1:0] output_latch;
		logic             port_ok;
	} result_t;

endpackage

@@ rtl/gpb_pin_lane.sv @@
// ----------------------------------------------------------------------------
// gpb_pin_lane
// State of one pin position across all ports; applies a command to that pin
// and gives the pin's output latch bit after the command.
// ----------------------------------------------------------------------------
module gpb_pin_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  gpb_pkg::lane_ctl_t ctl,
	input  logic              mask_bit,
	output logic              latch_bit
);

	logic [1:0] mode_q  [gpb_pkg::NUM_PORTS];
	logic [1:0] speed_q [gpb_pkg::NUM_PORTS];
	logic       od_q    [gpb_pkg::NUM_PORTS];
	logic [1:0] pull_q  [gpb_pkg::NUM_PORTS];
	logic [3:0] af_q    [gpb_pkg::NUM_PORTS];
	logic       latch_q [gpb_pkg::NUM_PORTS];

	logic [1:0] new_mode;
	logic       drives;

	assign new_mode = ctl.word[gpb_pkg::MODE_LSB +: 2];
	assign drives = (new_mode == gpb_pkg::MODE_OUTPUT) || (new_mode == gpb_pkg::MODE_ALT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < gpb_pkg::NUM_PORTS; p++) begin
				mode_q[p]  <= gpb_pkg::MODE_INPUT;
				speed_q[p] <= '0;
				od_q[p]    <= 1'b0;
				pull_q[p]  <= '0;
				af_q[p]    <= '0;
				latch_q[p] <= 1'b0;
			end
		end else if (ctl.wr && mask_bit) begin
			unique case (ctl.cmd)
				gpb_pkg::CMD_CONFIG: begin
					mode_q[ctl.port] <= new_mode;
					pull_q[ctl.port] <= ctl.word[gpb_pkg::PULL_LSB +: 2];
					if (drives) begin
						speed_q[ctl.port] <= ctl.word[gpb_pkg::SPEED_LSB +: 2];
						od_q[ctl.port]    <= ctl.word[gpb_pkg::OD_BIT];
					end
					if (new_mode == gpb_pkg::MODE_ALT) begin
						af_q[ctl.port] <= ctl.word[gpb_pkg::AF_LSB +: 4];
					end
				end
				gpb_pkg::CMD_SET:   latch_q[ctl.port] <= 1'b1;
				gpb_pkg::CMD_CLEAR: latch_q[ctl.port] <= 1'b0;
				default: ;
			endcase
		end
	end

	// latch bit as it stands after this item
	always_comb begin
		latch_bit = latch_q[ctl.port];
		if (mask_bit) begin
			case (ctl.cmd)
				gpb_pkg::CMD_SET:   latch_bit = 1'b1;
				gpb_pkg::CMD_CLEAR: latch_bit = 1'b0;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/gpb_merge.sv @@
// ----------------------------------------------------------------------------
// gpb_merge
// Output register and skid stage that hold merged lane results until taken.
// ----------------------------------------------------------------------------
module gpb_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  gpb_pkg::result_t res,
	output logic             in_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output gpb_pkg::result_t out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	gpb_pkg::result_t out_q;
	gpb_pkg::result_t skid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;
	assign in_ready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign out_res  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid filled without an output stall");

	a_direct_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !out_valid_q) |=> (out_valid_q && out_q == $past(res)))
		else $error("item not loaded into empty output register");
`endif

endmodule

@@ rtl/gpio_port_bank.sv @@
// ----------------------------------------------------------------------------
// gpio_port_bank
// Bank of gpio ports; each item configures, sets, clears or reads one port.
// ----------------------------------------------------------------------------
// results are registered: an accepted item loads the output register, or the skid while that stalls
// throughput: one item per cycle while the skid is empty, set by the per-pin lane update
// a two-deep output stage (register plus skid) takes one more item while a
// result stalls; a longer stall closes the input until the skid drains
// reset clears every port to input mode, no pull, push-pull, latch low
module gpio_port_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], port_select[9:2], pin_mask[25:10], mode_word[37:26],
	// pin_levels[53:38], zero fill [55:54]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[15:0], output_latch[31:16], port_ok[32], zero fill [39:33]
	output logic [39:0] m_tdata
);

	logic [gpb_pkg::CMD_W-1:0]  command;
	logic [gpb_pkg::SEL_W-1:0]  port_select;
	logic [gpb_pkg::PIN_W-1:0]  pin_mask;
	logic [gpb_pkg::WORD_W-1:0] mode_word;
	logic [gpb_pkg::PIN_W-1:0]  pin_levels;
	logic                       accept;
	logic                       port_ok;
	logic [gpb_pkg::PIN_W-1:0]  lane_bits;
	gpb_pkg::lane_ctl_t         ctl;
	gpb_pkg::result_t           res;
	gpb_pkg::result_t           out_res;

	assign command     = s_tdata[1:0];
	assign port_select = s_tdata[9:2];
	assign pin_mask    = s_tdata[25:10];
	assign mode_word   = s_tdata[37:26];
	assign pin_levels  = s_tdata[53:38];

	assign accept  = s_tvalid && s_tready;
	assign port_ok = port_select < gpb_pkg::SEL_W'(gpb_pkg::NUM_PORTS);

	assign ctl.wr   = accept && port_ok;
	assign ctl.cmd  = command;
	assign ctl.port = port_select[gpb_pkg::PORT_W-1:0];
	assign ctl.word = mode_word;

	for (genvar i = 0; i < gpb_pkg::PIN_W; i++) begin : g_lane
		if (i < gpb_pkg::PINS_PER_PORT) begin : g_pin
			gpb_pin_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.mask_bit  (pin_mask[i]),
				.latch_bit (lane_bits[i])
			);
		end else begin : g_none
			assign lane_bits[i] = 1'b0;
		end
	end

	// merge lane results into one item
	assign res.port_ok      = port_ok;
	assign res.output_latch = port_ok ? lane_bits : '0;
	assign res.read_data    = (port_ok && command == gpb_pkg::CMD_READ) ?
		(pin_levels & gpb_pkg::PIN_MASK) : '0;

	gpb_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.res      (res),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {7'd0, out_res.port_ok, out_res.output_latch, out_res.read_data};

endmodule
